[rtl/core/xcsd_pkg.sv]
// ----------------------------------------------------------------------------
// XOR-checked sentence deframer package
// Shared types, character constants and the checksum digit decoder.
// ----------------------------------------------------------------------------
package xcsd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned CFG_INDEX_W = 2;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam kind_t KIND_PAYLOAD  = 2'd0;
    localparam kind_t KIND_ACCEPT   = 2'd1;
    localparam kind_t KIND_MISMATCH = 2'd2;
    localparam kind_t KIND_NO_TERM  = 2'd3;

    localparam cfg_index_t CFG_PAYLOAD_LENGTH = 2'd0;
    localparam cfg_index_t CFG_START_CHAR     = 2'd1;
    localparam cfg_index_t CFG_END_CHAR       = 2'd2;

    localparam byte_t RST_PAYLOAD_LENGTH = 8'd116;
    localparam byte_t RST_START_CHAR     = 8'h24;
    localparam byte_t RST_END_CHAR       = 8'h2A;

    localparam byte_t CHAR_NINE      = 8'h39;
    localparam byte_t CHAR_ZERO      = 8'h30;
    localparam byte_t CHAR_UPPER_A   = 8'h41;
    localparam byte_t HEX_LETTER_OFS = 8'd10;

    typedef enum logic [4:0] {
        PH_HUNT = 5'b00001,
        PH_DATA = 5'b00010,
        PH_TERM = 5'b00100,
        PH_HEX1 = 5'b01000,
        PH_HEX2 = 5'b10000
    } phase_t;

    typedef struct packed {
        byte_t payload_length;
        byte_t start_char;
        byte_t end_char;
    } cfg_t;

    typedef struct packed {
        kind_t kind;
        byte_t payload_byte;
        byte_t position;
        logic  is_last;
        byte_t computed_sum;
        byte_t received_sum;
    } result_t;

    // Digits up to '9' count from '0'; everything else counts as a letter from 'A'.
    function automatic byte_t hex_value(input byte_t c);
        byte_t v;
        if (c <= CHAR_NINE)
        begin
            v = c - CHAR_ZERO;
        end
        else
        begin
            v = c - CHAR_UPPER_A + HEX_LETTER_OFS;
        end
        return v;
    endfunction

endpackage

[rtl/core/xcsd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Configuration registers
// Holds payload length, start character and terminator character.
// ----------------------------------------------------------------------------
module xcsd_cfg_regs
    import xcsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  cfg_index_t cfg_index,
    input  byte_t      cfg_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_PAYLOAD_LENGTH: cfg_next.payload_length = cfg_data;
                CFG_START_CHAR:     cfg_next.start_char     = cfg_data;
                CFG_END_CHAR:       cfg_next.end_char       = cfg_data;
                default:            cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.payload_length <= RST_PAYLOAD_LENGTH;
            cfg_reg.start_char     <= RST_START_CHAR;
            cfg_reg.end_char       <= RST_END_CHAR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/xcsd_frame_fsm.sv]
// ----------------------------------------------------------------------------
// Sentence framing state machine
// Registers each input byte, then steps the framing state and builds the result.
// ----------------------------------------------------------------------------
module xcsd_frame_fsm
    import xcsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  byte_t   in_byte,
    output logic    in_stall,
    input  cfg_t    cfg,
    input  logic    out_ready,
    output logic    res_valid,
    output result_t res
);

    logic   s1_valid_reg;
    logic   s1_valid_next;
    byte_t  s1_byte_reg;
    byte_t  s1_byte_next;
    logic   advance;
    logic   in_accept;

    phase_t     phase_reg;
    phase_t     phase_next;
    byte_t      count_reg;
    byte_t      count_next;
    byte_t      xor_reg;
    byte_t      xor_next;
    logic [3:0] nibble_reg;
    logic [3:0] nibble_next;

    byte_t b;
    byte_t last_pos;
    byte_t rsum;
    byte_t lo_value;

    assign advance   = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_byte_next  = s1_byte_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
            s1_byte_next  = in_byte;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    assign b        = s1_byte_reg;
    assign last_pos = cfg.payload_length - 8'd1;
    assign lo_value = hex_value(b);
    assign rsum     = {nibble_reg, 4'b0000} + lo_value;

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        xor_next    = xor_reg;
        nibble_next = nibble_reg;
        res_valid   = 1'b0;
        res         = '0;
        if (advance)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (b == cfg.start_char)
                    begin
                        phase_next = PH_DATA;
                        count_next = '0;
                        xor_next   = '0;
                    end
                end
                PH_DATA:
                begin
                    xor_next         = xor_reg ^ b;
                    count_next       = count_reg + 8'd1;
                    res_valid        = 1'b1;
                    res.kind         = KIND_PAYLOAD;
                    res.payload_byte = b;
                    res.position     = count_reg;
                    if (count_reg == last_pos)
                    begin
                        res.is_last = 1'b1;
                        phase_next  = PH_TERM;
                    end
                end
                PH_TERM:
                begin
                    if (b == cfg.end_char)
                    begin
                        phase_next = PH_HEX1;
                    end
                    else
                    begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_NO_TERM;
                        res.computed_sum = xor_reg;
                        phase_next       = PH_HUNT;
                    end
                end
                PH_HEX1:
                begin
                    nibble_next = lo_value[3:0];
                    phase_next  = PH_HEX2;
                end
                PH_HEX2:
                begin
                    res_valid        = 1'b1;
                    res.kind         = (rsum == xor_reg) ? KIND_ACCEPT : KIND_MISMATCH;
                    res.computed_sum = xor_reg;
                    res.received_sum = rsum;
                    phase_next       = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            phase_reg    <= PH_HUNT;
            count_reg    <= '0;
            xor_reg      <= '0;
            nibble_reg   <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            xor_reg      <= xor_next;
            nibble_reg   <= nibble_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_byte_reg <= s1_byte_next;
    end

`ifndef NO_ASSERTIONS
    a_data_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase_reg == PH_DATA) |-> res_valid)
        else $error("payload byte produced no result");

    a_last_goes_term: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == KIND_PAYLOAD && res.is_last) |=> (phase_reg == PH_TERM))
        else $error("final payload byte did not lead to terminator check");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && !advance))
        else $error("input stalled with no held request");

    a_status_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind != KIND_PAYLOAD) |=> (phase_reg == PH_HUNT))
        else $error("status result did not return to hunting");
`endif

endmodule

[rtl/core/xcsd_out_reg.sv]
// ----------------------------------------------------------------------------
// Result register
// Holds one finished result until the downstream side takes it.
// ----------------------------------------------------------------------------
module xcsd_out_reg
    import xcsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res_d,
    input  logic    out_stall,
    output logic    out_ready,
    output logic    out_valid,
    output result_t out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;
    result_t res_next;

    assign out_ready = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (load)
        begin
            valid_next = 1'b1;
            res_next   = res_d;
        end
        else if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

[rtl/core/xor_checked_sentence_deframer_unit.sv]
// ----------------------------------------------------------------------------
// XOR-checked sentence deframer
// Hunts for a start character, passes payload bytes on with their position,
// then checks the terminator and a two-character hex XOR checksum.
// ----------------------------------------------------------------------------
// The unit takes one byte request per clock cycle and keeps that rate as long as
// the output side does not stall. Each byte is held in an input register and
// processed by the framing state machine once the output register can take a
// result. A result passes through the input register and then the output
// register before it is presented. A stall on the output backs up through the
// single input register to in_stall in the same cycle. Configuration is taken
// on any cycle with cfg_write_en high; writes to an index past the
// end-character register are ignored.
module xor_checked_sentence_deframer_unit
    import xcsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  cfg_index_t cfg_index,
    input  byte_t      cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  byte_t      in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output kind_t      kind,
    output byte_t      payload_byte,
    output byte_t      position,
    output logic       is_last,
    output byte_t      computed_sum,
    output byte_t      received_sum
);

    cfg_t    cfg;
    logic    out_ready;
    logic    res_valid;
    result_t res;
    result_t out_res;

    xcsd_cfg_regs u_cfg_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    xcsd_frame_fsm u_frame_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_byte   (in_byte),
        .in_stall  (in_stall),
        .cfg       (cfg),
        .out_ready (out_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    xcsd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res_d     (res),
        .out_stall (out_stall),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign kind         = out_res.kind;
    assign payload_byte = out_res.payload_byte;
    assign position     = out_res.position;
    assign is_last      = out_res.is_last;
    assign computed_sum = out_res.computed_sum;
    assign received_sum = out_res.received_sum;

endmodule
